[src/cmps_pkg.sv]
package cmps_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_MOD,
    ST_DIV_WHOLE,
    ST_CLOSE,
    ST_DIV_RATIO,
    ST_FINAL,
    ST_DIV_PAVG,
    ST_DIV_IAVG,
    ST_DONE
  } state_t;

  // which counter a covered operation feeds
  typedef enum logic [1:0] {
    KIND_MATCH,
    KIND_MISMATCH,
    KIND_DEL
  } kind_t;

  localparam int CNT_W   = 20;
  localparam int PSUM_W  = 40;
  localparam int ISUM_W  = 32;
  localparam int MOTIF_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_EQ = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_D  = 8'h44;
  localparam logic [CHAR_W-1:0] CH_I  = 8'h49;

endpackage

[src/cigar_motif_purity_stats_top.sv]
// a digit passes through EXEC and back to IDLE; an operation that fills a motif
// takes up to three passes of the shared restoring divider (one quotient bit per
// cycle); the final character adds up to three more passes (the partial motif
// ratio and both averages) and then hands the result over from DONE
// throughput: one character at a time, in_ready is low while the sequencer runs
// reset: rst (synchronous) clears all counters and sums and sets motif length 1
module cigar_motif_purity_stats_top #(
  parameter int LENGTH_BITS   = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmps_pkg::MOTIF_W-1:0]        cfg_data,
  // character input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cmps_pkg::CHAR_W-1:0]         cigar_char,
  input  logic                                last_char,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [FRACTION_BITS:0]              avg_purity,
  output logic [cmps_pkg::CNT_W-1:0]          avg_indels,
  output logic [cmps_pkg::CNT_W-1:0]          motif_count
);

  localparam int CW    = cmps_pkg::CNT_W;
  localparam int PW    = cmps_pkg::PSUM_W;
  localparam int IW    = cmps_pkg::ISUM_W;
  localparam int MW    = cmps_pkg::MOTIF_W;
  // covered count plus run length
  localparam int TOT_W = ((LENGTH_BITS > CW) ? LENGTH_BITS : CW) + 1;
  // ratio dividend is the match count scaled to Q.FRACTION_BITS
  localparam int RAT_W = CW + FRACTION_BITS;
  localparam int DW_A  = (RAT_W > PW) ? RAT_W : PW;
  localparam int DIV_W = (DW_A > TOT_W) ? DW_A : TOT_W;
  // divisor: largest is match + mismatch + indel
  localparam int DVW   = CW + 2;
  localparam int DCW   = $clog2(DIV_W + 1);
  // purity sum plus whole-motif entries
  localparam int WS_W  = ((PW > LENGTH_BITS + FRACTION_BITS) ? PW
                          : LENGTH_BITS + FRACTION_BITS) + 1;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [CW-1:0]          CNT_MAX = {CW{1'b1}};
  localparam logic [PW-1:0]          PSUM_MAX = {PW{1'b1}};
  localparam logic [IW-1:0]          ISUM_MAX = {IW{1'b1}};
  localparam logic [DIV_W-1:0]       ONE_Q = DIV_W'(1) << FRACTION_BITS;

  cmps_pkg::state_t state, state_next;
  cmps_pkg::kind_t  op_kind, op_kind_next;

  logic [MW-1:0]          unit_len;
  logic [cmps_pkg::CHAR_W-1:0] char_reg, char_reg_next;
  logic                   last_reg, last_reg_next;
  logic                   in_final, in_final_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] op_len, op_len_next;
  logic [MW-1:0]          excess, excess_next;
  logic [CW-1:0]          covered_count, covered_count_next;
  logic [CW-1:0]          match_count, match_count_next;
  logic [CW-1:0]          mismatch_count, mismatch_count_next;
  logic [CW-1:0]          indel_count, indel_count_next;
  logic [PW-1:0]          purity_sum, purity_sum_next;
  logic [CW-1:0]          purity_entries, purity_entries_next;
  logic [IW-1:0]          indel_sum, indel_sum_next;
  logic [CW-1:0]          indel_entries, indel_entries_next;
  logic [FRACTION_BITS:0] res_p, res_p_next;
  logic [CW-1:0]          res_i, res_i_next;
  logic                   out_valid_next;
  logic [FRACTION_BITS:0] avg_purity_next;
  logic [CW-1:0]          avg_indels_next;
  logic [CW-1:0]          motif_count_next;

  // shared restoring divider
  logic [DIV_W-1:0] div_quo, div_quo_next;
  logic [DVW-1:0]   div_rem, div_rem_next;
  logic [DVW-1:0]   div_den, div_den_next;
  logic [DCW-1:0]   div_cnt, div_cnt_next;
  logic [DVW:0]     rem_sh;
  logic             div_ge;
  logic [DIV_W-1:0] q_new;
  logic [DVW-1:0]   r_new;
  logic             div_last;

  assign rem_sh   = {div_rem, div_quo[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den};
  assign r_new    = div_ge ? DVW'(rem_sh - {1'b0, div_den}) : rem_sh[DVW-1:0];
  assign q_new    = {div_quo[DIV_W-2:0], div_ge};
  assign div_last = (div_cnt == DCW'(1));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == cmps_pkg::ST_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_len <= MW'(1);
    end else if (cfg_valid) begin
      unit_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= cmps_pkg::ST_IDLE;
      out_valid      <= 1'b0;
      length_accum   <= '0;
      covered_count  <= '0;
      match_count    <= '0;
      mismatch_count <= '0;
      indel_count    <= '0;
      purity_sum     <= '0;
      purity_entries <= '0;
      indel_sum      <= '0;
      indel_entries  <= '0;
      in_final       <= 1'b0;
      div_cnt        <= '0;
    end else begin
      state          <= state_next;
      out_valid      <= out_valid_next;
      length_accum   <= length_accum_next;
      covered_count  <= covered_count_next;
      match_count    <= match_count_next;
      mismatch_count <= mismatch_count_next;
      indel_count    <= indel_count_next;
      purity_sum     <= purity_sum_next;
      purity_entries <= purity_entries_next;
      indel_sum      <= indel_sum_next;
      indel_entries  <= indel_entries_next;
      in_final       <= in_final_next;
      div_cnt        <= div_cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_reg    <= char_reg_next;
    last_reg    <= last_reg_next;
    op_kind     <= op_kind_next;
    op_len      <= op_len_next;
    excess      <= excess_next;
    res_p       <= res_p_next;
    res_i       <= res_i_next;
    div_quo     <= div_quo_next;
    div_rem     <= div_rem_next;
    div_den     <= div_den_next;
    avg_purity  <= avg_purity_next;
    avg_indels  <= avg_indels_next;
    motif_count <= motif_count_next;
  end

  always_comb begin
    logic [MW-1:0]            m_eff;
    logic [LENGTH_BITS+3:0]   dig_v;
    logic [TOT_W-1:0]         total;
    logic [TOT_W-1:0]         cnt_sum;
    logic [LENGTH_BITS-1:0]   take;
    logic [CW-1:0]            ctr_val;
    logic [CW-1:0]            ctr_new;
    logic [WS_W-1:0]          ps_sum;
    logic [DIV_W-1:0]         ratio;
    logic [DVW-1:0]           den;
    logic [IW:0]              is_sum;
    logic [DIV_W-1:0]         ap;
    logic [DIV_W-1:0]         ai;
    logic                     load_en;
    logic [DIV_W-1:0]         load_a;
    logic [DVW-1:0]           load_b;

    state_next          = state;
    op_kind_next        = op_kind;
    char_reg_next       = char_reg;
    last_reg_next       = last_reg;
    in_final_next       = in_final;
    length_accum_next   = length_accum;
    op_len_next         = op_len;
    excess_next         = excess;
    covered_count_next  = covered_count;
    match_count_next    = match_count;
    mismatch_count_next = mismatch_count;
    indel_count_next    = indel_count;
    purity_sum_next     = purity_sum;
    purity_entries_next = purity_entries;
    indel_sum_next      = indel_sum;
    indel_entries_next  = indel_entries;
    res_p_next          = res_p;
    res_i_next          = res_i;
    avg_purity_next     = avg_purity;
    avg_indels_next     = avg_indels;
    motif_count_next    = motif_count;
    out_valid_next      = out_valid && !out_ready;
    div_quo_next        = div_quo;
    div_rem_next        = div_rem;
    div_den_next        = div_den;
    div_cnt_next        = div_cnt;

    m_eff   = (unit_len == '0) ? MW'(1) : unit_len;
    dig_v   = '0;
    total   = TOT_W'(covered_count) + TOT_W'(op_len);
    cnt_sum = '0;
    take    = '0;
    ctr_val = '0;
    ctr_new = '0;
    ps_sum  = '0;
    ratio   = '0;
    den     = DVW'(match_count) + DVW'(mismatch_count) + DVW'(indel_count);
    is_sum  = '0;
    ap      = '0;
    ai      = '0;
    load_en = 1'b0;
    load_a  = '0;
    load_b  = '0;

    // divider steps in every division state
    if (state == cmps_pkg::ST_DIV_MOD || state == cmps_pkg::ST_DIV_WHOLE ||
        state == cmps_pkg::ST_DIV_RATIO || state == cmps_pkg::ST_DIV_PAVG ||
        state == cmps_pkg::ST_DIV_IAVG) begin
      div_quo_next = q_new;
      div_rem_next = r_new;
      div_cnt_next = div_cnt - DCW'(1);
    end

    case (state)
      cmps_pkg::ST_IDLE: begin
        if (in_valid) begin
          char_reg_next = cigar_char;
          last_reg_next = last_char;
          in_final_next = 1'b0;
          state_next    = cmps_pkg::ST_EXEC;
        end
      end

      cmps_pkg::ST_EXEC: begin
        state_next = last_reg ? cmps_pkg::ST_FINAL : cmps_pkg::ST_IDLE;
        if (char_reg >= cmps_pkg::CH_0 && char_reg <= cmps_pkg::CH_9) begin
          // accum * 10 + digit, saturating
          dig_v = ((LENGTH_BITS+4)'(length_accum) << 3) +
                  ((LENGTH_BITS+4)'(length_accum) << 1) +
                  (LENGTH_BITS+4)'(char_reg - cmps_pkg::CH_0);
          length_accum_next = (dig_v > (LENGTH_BITS+4)'(LEN_MAX)) ? LEN_MAX
                              : dig_v[LENGTH_BITS-1:0];
          // a digit on the last character is simply dropped
          if (last_reg) begin
            length_accum_next = '0;
          end
        end else begin
          length_accum_next = '0;
          op_len_next       = length_accum;
          total = TOT_W'(covered_count) + TOT_W'(length_accum);
          if (char_reg == cmps_pkg::CH_M || char_reg == cmps_pkg::CH_EQ ||
              char_reg == cmps_pkg::CH_X || char_reg == cmps_pkg::CH_D) begin
            if (char_reg == cmps_pkg::CH_X) begin
              op_kind_next = cmps_pkg::KIND_MISMATCH;
              ctr_val      = mismatch_count;
            end else if (char_reg == cmps_pkg::CH_D) begin
              op_kind_next = cmps_pkg::KIND_DEL;
              ctr_val      = indel_count;
            end else begin
              op_kind_next = cmps_pkg::KIND_MATCH;
              ctr_val      = match_count;
            end
            if (total >= TOT_W'(m_eff)) begin
              // motif fills: need total mod m
              load_en    = 1'b1;
              load_a     = DIV_W'(total);
              load_b     = DVW'(m_eff);
              state_next = cmps_pkg::ST_DIV_MOD;
            end else begin
              covered_count_next = total[CW-1:0];
              cnt_sum = TOT_W'(ctr_val) + TOT_W'(length_accum);
              ctr_new = (cnt_sum > TOT_W'(CNT_MAX)) ? CNT_MAX : cnt_sum[CW-1:0];
              case (op_kind_next)
                cmps_pkg::KIND_MISMATCH: mismatch_count_next = ctr_new;
                cmps_pkg::KIND_DEL:      indel_count_next    = ctr_new;
                default:                 match_count_next    = ctr_new;
              endcase
            end
          end else if (char_reg == cmps_pkg::CH_I) begin
            cnt_sum = TOT_W'(indel_count) + TOT_W'(length_accum);
            indel_count_next = (cnt_sum > TOT_W'(CNT_MAX)) ? CNT_MAX
                               : cnt_sum[CW-1:0];
          end
        end
      end

      cmps_pkg::ST_DIV_MOD: begin
        if (div_last) begin
          excess_next = r_new[MW-1:0];
          take = (op_len >= LENGTH_BITS'(r_new[MW-1:0]))
                 ? LENGTH_BITS'(op_len - LENGTH_BITS'(r_new[MW-1:0])) : '0;
          case (op_kind)
            cmps_pkg::KIND_MISMATCH: ctr_val = mismatch_count;
            cmps_pkg::KIND_DEL:      ctr_val = indel_count;
            default:                 ctr_val = match_count;
          endcase
          cnt_sum = TOT_W'(ctr_val) + TOT_W'(take);
          ctr_new = (cnt_sum > TOT_W'(CNT_MAX)) ? CNT_MAX : cnt_sum[CW-1:0];
          case (op_kind)
            cmps_pkg::KIND_MISMATCH: mismatch_count_next = ctr_new;
            cmps_pkg::KIND_DEL:      indel_count_next    = ctr_new;
            default:                 match_count_next    = ctr_new;
          endcase
          if (op_kind == cmps_pkg::KIND_MATCH && op_len > LENGTH_BITS'(m_eff)) begin
            // long match run: whole-motif entries
            load_en    = 1'b1;
            load_a     = DIV_W'(op_len);
            load_b     = DVW'(m_eff);
            state_next = cmps_pkg::ST_DIV_WHOLE;
          end else begin
            state_next = cmps_pkg::ST_CLOSE;
          end
        end
      end

      cmps_pkg::ST_DIV_WHOLE: begin
        if (div_last) begin
          ps_sum = WS_W'(purity_sum) +
                   (WS_W'(q_new[LENGTH_BITS-1:0]) << FRACTION_BITS);
          purity_sum_next = (ps_sum > WS_W'(PSUM_MAX)) ? PSUM_MAX : ps_sum[PW-1:0];
          cnt_sum = TOT_W'(purity_entries) + TOT_W'(q_new[LENGTH_BITS-1:0]);
          purity_entries_next = (cnt_sum > TOT_W'(CNT_MAX)) ? CNT_MAX
                                : cnt_sum[CW-1:0];
          state_next = cmps_pkg::ST_CLOSE;
        end
      end

      cmps_pkg::ST_CLOSE: begin
        // unit ratio: match scaled over all positions in the unit
        load_en    = 1'b1;
        load_a     = DIV_W'({match_count, {FRACTION_BITS{1'b0}}});
        load_b     = den;
        state_next = cmps_pkg::ST_DIV_RATIO;
      end

      cmps_pkg::ST_DIV_RATIO: begin
        if (div_last) begin
          ratio  = (div_den == '0) ? '0 : q_new;
          ps_sum = WS_W'(purity_sum) + WS_W'(ratio[FRACTION_BITS:0]);
          purity_sum_next = (ps_sum > WS_W'(PSUM_MAX)) ? PSUM_MAX : ps_sum[PW-1:0];
          cnt_sum = TOT_W'(purity_entries) + TOT_W'(1);
          purity_entries_next = (cnt_sum > TOT_W'(CNT_MAX)) ? CNT_MAX
                                : cnt_sum[CW-1:0];
          is_sum = (IW+1)'(indel_sum) + (IW+1)'(indel_count);
          indel_sum_next = (is_sum > (IW+1)'(ISUM_MAX)) ? ISUM_MAX : is_sum[IW-1:0];
          cnt_sum = TOT_W'(indel_entries) + TOT_W'(1);
          indel_entries_next = (cnt_sum > TOT_W'(CNT_MAX)) ? CNT_MAX
                               : cnt_sum[CW-1:0];
          if (in_final) begin
            state_next = cmps_pkg::ST_FINAL;
          end else begin
            // start the next unit with the overflow of this run
            covered_count_next  = CW'(excess);
            match_count_next    = '0;
            mismatch_count_next = '0;
            indel_count_next    = '0;
            case (op_kind)
              cmps_pkg::KIND_MISMATCH: mismatch_count_next = CW'(excess);
              cmps_pkg::KIND_DEL:      indel_count_next    = CW'(excess);
              default:                 match_count_next    = CW'(excess);
            endcase
            state_next = last_reg ? cmps_pkg::ST_FINAL : cmps_pkg::ST_IDLE;
          end
        end
      end

      cmps_pkg::ST_FINAL: begin
        if (covered_count != '0 && !in_final) begin
          // close the partial unit first
          in_final_next = 1'b1;
          state_next    = cmps_pkg::ST_CLOSE;
        end else begin
          load_en    = 1'b1;
          load_a     = DIV_W'(purity_sum);
          load_b     = DVW'(purity_entries);
          state_next = cmps_pkg::ST_DIV_PAVG;
        end
      end

      cmps_pkg::ST_DIV_PAVG: begin
        if (div_last) begin
          ap = (q_new > ONE_Q) ? ONE_Q : q_new;
          res_p_next = (purity_entries == '0) ? '0 : ap[FRACTION_BITS:0];
          load_en    = 1'b1;
          load_a     = DIV_W'(indel_sum);
          load_b     = DVW'(indel_entries);
          state_next = cmps_pkg::ST_DIV_IAVG;
        end
      end

      cmps_pkg::ST_DIV_IAVG: begin
        if (div_last) begin
          ai = (q_new > DIV_W'(CNT_MAX)) ? DIV_W'(CNT_MAX) : q_new;
          res_i_next = (indel_entries == '0) ? '0 : ai[CW-1:0];
          state_next = cmps_pkg::ST_DONE;
        end
      end

      cmps_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          avg_purity_next     = res_p;
          avg_indels_next     = res_i;
          motif_count_next    = purity_entries;
          length_accum_next   = '0;
          covered_count_next  = '0;
          match_count_next    = '0;
          mismatch_count_next = '0;
          indel_count_next    = '0;
          purity_sum_next     = '0;
          purity_entries_next = '0;
          indel_sum_next      = '0;
          indel_entries_next  = '0;
          state_next          = cmps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cmps_pkg::ST_IDLE;
      end
    endcase

    if (load_en) begin
      div_quo_next = load_a;
      div_rem_next = '0;
      div_den_next = load_b;
      div_cnt_next = DCW'(DIV_W);
    end
  end

endmodule
